/* design/fca_pkg.sv */
package fca_pkg;

    // Field widths of the transaction payloads
    localparam int OPCODE_W  = 3;
    localparam int CLUSTER_W = 16;
    localparam int STATUS_W  = 2;
    localparam int CCOUNT_W  = 12;
    localparam int FREE_W    = 12;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 32;

    // Operation codes
    localparam logic [OPCODE_W-1:0] OP_ALLOC = 3'd0;
    localparam logic [OPCODE_W-1:0] OP_FREE  = 3'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 3'd2;
    localparam logic [OPCODE_W-1:0] OP_WRITE = 3'd3;
    localparam logic [OPCODE_W-1:0] OP_COUNT = 3'd4;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Link values
    localparam logic [CLUSTER_W-1:0] END_OF_CHAIN = 16'hFFFF;
    localparam logic [CLUSTER_W-1:0] EOC_MIN      = 16'hFFF8;
    localparam logic [CLUSTER_W-1:0] FREE_LINK    = 16'h0000;

    localparam logic [CCOUNT_W-1:0] CCOUNT_RESET = 12'd4094;

endpackage

/* design/fca_link_ram.sv */
module fca_link_ram #(
    parameter int DEPTH = 4096
) (
    input  logic                       clk,
    input  logic                       we,
    input  logic [$clog2(DEPTH)-1:0]   waddr,
    input  logic [fca_pkg::CLUSTER_W-1:0] wdata,
    input  logic                       re,
    input  logic [$clog2(DEPTH)-1:0]   raddr,
    output logic [fca_pkg::CLUSTER_W-1:0] rdata
);
    import fca_pkg::*;

    logic [CLUSTER_W-1:0] mem [DEPTH];

    // One write port and one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/fat_cluster_allocator_top.sv */
// FAT16-style cluster chain allocator.
//
// Input channel s_*: one transaction carries an operation (allocate, free
// chain, read entry, write entry, count free) with a cluster number and a
// write value. Output channel m_*: exactly one result transaction per input
// transaction, in order, with status, result value and free count.
// cfg_wr_en/cfg_wr_data load the cluster count register; write it only while
// no operation is in flight.
//
// Timing: the block works on one operation at a time and drops s_tready until the result
// has been loaded into the output register. The link table sits in a RAM with one write
// port and one registered read port, and every table access goes through them. Allocate
// and count free stream one entry per cycle. Free chain reads each link in S_FREE_RD, frees
// it in S_FREE_CHK. Read entry takes the RAM data in S_READ_WAIT.
//
// Reset: the control state clears at once, then a clearing pass writes every
// table entry (entries 0 and 1 to end-of-chain, the rest to free), with
// s_tready low. Configuration writes are taken during the pass. When the
// receiver stalls, the finished result holds in the output register and
// the result of the next operation waits in S_FINISH until it is taken.
module fat_cluster_allocator_top #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // config: cluster_count
    input  logic                          cfg_wr_en,
    input  logic [fca_pkg::CCOUNT_W-1:0]  cfg_wr_data,
    // s_tdata: opcode[2:0], cluster[18:3], write_value[34:19], zero fill
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fca_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: status[1:0], result_value[17:2], free_count[29:18], zero fill
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fca_pkg::M_TDATA_W-1:0] m_tdata
);
    import fca_pkg::*;

    localparam int AW     = $clog2(TABLE_ENTRIES);
    localparam int MAX_CC = TABLE_ENTRIES - 2;

    // Sequencer state codes
    localparam logic [3:0] S_CLEAR     = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_ALLOC     = 4'd2;
    localparam logic [3:0] S_LINK      = 4'd3;
    localparam logic [3:0] S_FREE_RD   = 4'd4;
    localparam logic [3:0] S_FREE_CHK  = 4'd5;
    localparam logic [3:0] S_READ_WAIT = 4'd6;
    localparam logic [3:0] S_COUNT     = 4'd7;
    localparam logic [3:0] S_FINISH    = 4'd8;

    // Range checks against the last valid index
    function automatic logic fits_read(input logic [CLUSTER_W-1:0] x,
                                       input logic [CLUSTER_W-1:0] lim);
        fits_read = (x <= lim);
    endfunction

    function automatic logic fits_write(input logic [CLUSTER_W-1:0] x,
                                        input logic [CLUSTER_W-1:0] lim);
        fits_write = (x >= CLUSTER_W'(2)) && (x <= lim);
    endfunction

    logic [3:0]            state_reg, state_next;
    logic [CCOUNT_W-1:0]   cc_reg;
    logic [AW-1:0]         search_start_reg, search_start_next;
    logic [AW-1:0]         scan_addr_reg, scan_addr_next;
    logic [AW-1:0]         chk_addr_reg, chk_addr_next;
    logic                  chk_valid_reg, chk_valid_next;
    logic [AW-1:0]         issue_cnt_reg, issue_cnt_next;
    logic [CLUSTER_W-1:0]  cur_reg, cur_next;
    logic [CLUSTER_W-1:0]  op_cluster_reg, op_cluster_next;
    logic [STATUS_W-1:0]   res_status_reg, res_status_next;
    logic [CLUSTER_W-1:0]  res_value_reg, res_value_next;
    logic [FREE_W-1:0]     res_free_reg, res_free_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0]  m_tdata_reg, m_tdata_next;

    logic [OPCODE_W-1:0]   in_opcode;
    logic [CLUSTER_W-1:0]  in_cluster;
    logic [CLUSTER_W-1:0]  in_write_value;

    logic [AW-1:0]         eff_cc;
    logic [CLUSTER_W-1:0]  last_idx;
    logic [AW-1:0]         alloc_cand;
    logic                  accept;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [CLUSTER_W-1:0]  mem_wdata;
    logic                  mem_re;
    logic [AW-1:0]         mem_raddr;
    logic [CLUSTER_W-1:0]  mem_rdata;

    assign in_opcode      = s_tdata[2:0];
    assign in_cluster     = s_tdata[18:3];
    assign in_write_value = s_tdata[34:19];

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // Clamp the cluster count to what the table can hold
    always_comb
    begin
        if (17'(cc_reg) > 17'(MAX_CC))
        begin
            eff_cc = AW'(MAX_CC);
        end
        else
        begin
            eff_cc = AW'(cc_reg);
        end
    end

    assign last_idx = CLUSTER_W'(eff_cc) + CLUSTER_W'(1);

    // Next-fit candidate: wrap to entry 2 past the last data cluster
    assign alloc_cand = ((scan_addr_reg > eff_cc) ? AW'(1) : scan_addr_reg) + AW'(1);

    fca_link_ram #(
        .DEPTH (TABLE_ENTRIES)
    ) u_link_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_comb
    begin
        state_next        = state_reg;
        search_start_next = search_start_reg;
        scan_addr_next    = scan_addr_reg;
        chk_addr_next     = chk_addr_reg;
        chk_valid_next    = chk_valid_reg;
        issue_cnt_next    = issue_cnt_reg;
        cur_next          = cur_reg;
        op_cluster_next   = op_cluster_reg;
        res_status_next   = res_status_reg;
        res_value_next    = res_value_reg;
        res_free_next     = res_free_reg;
        m_tvalid_next     = m_tvalid_reg;
        m_tdata_next      = m_tdata_reg;

        mem_we    = 1'b0;
        mem_waddr = scan_addr_reg;
        mem_wdata = FREE_LINK;
        mem_re    = 1'b0;
        mem_raddr = scan_addr_reg;

        // Retire the result transaction when the receiver takes it
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the table once after reset
                mem_we    = 1'b1;
                mem_waddr = scan_addr_reg;
                mem_wdata = (scan_addr_reg < AW'(2)) ? END_OF_CHAIN : FREE_LINK;
                scan_addr_next = scan_addr_reg + AW'(1);
                if (scan_addr_reg == AW'(TABLE_ENTRIES - 1))
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    op_cluster_next = in_cluster;
                    res_status_next = ST_OK;
                    res_value_next  = '0;
                    res_free_next   = '0;
                    chk_valid_next  = 1'b0;
                    issue_cnt_next  = '0;
                    unique case (in_opcode)
                        OP_ALLOC:
                        begin
                            scan_addr_next = search_start_reg;
                            state_next     = S_ALLOC;
                        end
                        OP_FREE:
                        begin
                            cur_next   = in_cluster;
                            state_next = S_FREE_RD;
                        end
                        OP_READ:
                        begin
                            if (fits_read(in_cluster, last_idx))
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = in_cluster[AW-1:0];
                                state_next = S_READ_WAIT;
                            end
                            else
                            begin
                                res_status_next = ST_RANGE;
                                state_next      = S_FINISH;
                            end
                        end
                        OP_WRITE:
                        begin
                            if (fits_write(in_cluster, last_idx))
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = in_cluster[AW-1:0];
                                mem_wdata = in_write_value;
                            end
                            else
                            begin
                                res_status_next = ST_RANGE;
                            end
                            state_next = S_FINISH;
                        end
                        OP_COUNT:
                        begin
                            scan_addr_next = AW'(2);
                            state_next     = S_COUNT;
                        end
                        default:
                        begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end

            S_ALLOC:
            begin
                if (chk_valid_reg && (mem_rdata == FREE_LINK))
                begin
                    // Claim the free entry, then link it after the tail if one is given and in range
                    mem_we    = 1'b1;
                    mem_waddr = chk_addr_reg;
                    mem_wdata = END_OF_CHAIN;
                    if ((op_cluster_reg != '0) && !fits_write(op_cluster_reg, last_idx))
                    begin
                        res_status_next = ST_RANGE;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        search_start_next = chk_addr_reg;
                        res_value_next    = CLUSTER_W'(chk_addr_reg);
                        state_next = (op_cluster_reg != '0) ? S_LINK : S_FINISH;
                    end
                end
                else if (issue_cnt_reg < eff_cc)
                begin
                    // Issue the next candidate while the previous one is checked
                    mem_re         = 1'b1;
                    mem_raddr      = alloc_cand;
                    scan_addr_next = alloc_cand;
                    chk_addr_next  = alloc_cand;
                    chk_valid_next = 1'b1;
                    issue_cnt_next = issue_cnt_reg + AW'(1);
                end
                else if (chk_valid_reg)
                begin
                    chk_valid_next = 1'b0;
                end
                else
                begin
                    res_status_next = ST_FULL;
                    state_next      = S_FINISH;
                end
            end

            S_LINK:
            begin
                mem_we     = 1'b1;
                mem_waddr  = op_cluster_reg[AW-1:0];
                mem_wdata  = CLUSTER_W'(chk_addr_reg);
                state_next = S_FINISH;
            end

            S_FREE_RD:
            begin
                if (fits_read(cur_reg, last_idx))
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = cur_reg[AW-1:0];
                    state_next = S_FREE_CHK;
                end
                else
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_FINISH;
                end
            end

            S_FREE_CHK:
            begin
                if (!fits_write(cur_reg, last_idx))
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_FINISH;
                end
                else
                begin
                    // Free this link and pull the search pointer back
                    mem_we    = 1'b1;
                    mem_waddr = cur_reg[AW-1:0];
                    mem_wdata = FREE_LINK;
                    if (cur_reg[AW-1:0] <= search_start_reg)
                    begin
                        search_start_next = cur_reg[AW-1:0] - AW'(1);
                    end
                    if (mem_rdata >= EOC_MIN)
                    begin
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        cur_next   = mem_rdata;
                        state_next = S_FREE_RD;
                    end
                end
            end

            S_READ_WAIT:
            begin
                res_value_next = mem_rdata;
                state_next     = S_FINISH;
            end

            S_COUNT:
            begin
                if (chk_valid_reg && (mem_rdata == FREE_LINK))
                begin
                    res_free_next = res_free_reg + FREE_W'(1);
                end
                if (issue_cnt_reg < eff_cc)
                begin
                    mem_re         = 1'b1;
                    mem_raddr      = scan_addr_reg;
                    scan_addr_next = scan_addr_reg + AW'(1);
                    chk_valid_next = 1'b1;
                    issue_cnt_next = issue_cnt_reg + AW'(1);
                end
                else
                begin
                    chk_valid_next = 1'b0;
                    if (!chk_valid_reg)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_FINISH:
            begin
                // Load the output register once it is free
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {2'b00, res_free_reg, res_value_reg, res_status_reg};
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            cc_reg           <= CCOUNT_RESET;
            search_start_reg <= AW'(1);
            scan_addr_reg    <= '0;
            chk_valid_reg    <= 1'b0;
            issue_cnt_reg    <= '0;
            m_tvalid_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            search_start_reg <= search_start_next;
            scan_addr_reg    <= scan_addr_next;
            chk_valid_reg    <= chk_valid_next;
            issue_cnt_reg    <= issue_cnt_next;
            m_tvalid_reg     <= m_tvalid_next;
            if (cfg_wr_en)
            begin
                cc_reg <= cfg_wr_data;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        chk_addr_reg   <= chk_addr_next;
        cur_reg        <= cur_next;
        op_cluster_reg <= op_cluster_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_free_reg   <= res_free_next;
        m_tdata_reg    <= m_tdata_next;
    end

`ifndef SYNTH
    // The search pointer never points at entry 0
    a_search_start_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        search_start_reg != '0)
        else $error("search pointer reached entry 0");

    // A link write only happens after the tail passed its range check
    a_link_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LINK |-> (op_cluster_reg >= CLUSTER_W'(2)) &&
                                (op_cluster_reg <= last_idx))
        else $error("link write outside the data clusters");

    // The scan never issues more reads than there are data clusters
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ALLOC || state_reg == S_COUNT) |-> issue_cnt_reg <= eff_cc)
        else $error("scan ran past the cluster count");

    // A finished result enters the output register and the block returns to idle
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINISH && (!m_tvalid_reg || m_tready) |=>
            m_tvalid_reg && state_reg == S_IDLE)
        else $error("result not loaded on finish");
`endif

endmodule
